>>> hdl/quick_find_edge_classifier_defines.svh
// ---------------------------------------------------------------------------
// quick find edge classifier assertion macros
// shared concurrent check forms, sampled on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef QUICK_FIND_EDGE_CLASSIFIER_DEFINES_SVH
`define QUICK_FIND_EDGE_CLASSIFIER_DEFINES_SVH

// condition must hold in the same cycle as the antecedent
`define QFEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the antecedent
`define QFEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/qfec_pkg.sv
// ---------------------------------------------------------------------------
// qfec_pkg
// types and constants shared by the quick find edge classifier modules
// ---------------------------------------------------------------------------
package qfec_pkg;

  localparam int VERTEX_W   = 8;
  localparam int VCOUNT_W   = 9;
  localparam int LOOP_W     = 16;
  localparam int CLASS_W    = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;
  localparam logic [LOOP_W-1:0]   LOOP_MAX     = 16'hFFFF;

  // register index taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // result classes
  localparam logic [CLASS_W-1:0] CLS_SELF_LOOP = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_FOREST    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_CYCLE     = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_RESTART   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_INVALID   = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_LOOK_LO,
    ST_LOOK_HI,
    ST_MATCH,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  mode;
    logic [VERTEX_W-1:0]   vertex_a;
    logic [VERTEX_W-1:0]   vertex_b;
  } edge_req_t;

  typedef struct packed {
    logic [CLASS_W-1:0]    edge_class;
    logic [VERTEX_W-1:0]   low_end;
    logic [VERTEX_W-1:0]   high_end;
    logic [LOOP_W-1:0]     loop_total;
  } result_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic restart;
    logic invalid;
    logic self_loop;
    logic labels_equal;
  } qfec_stat_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    state_t             state;
    logic [CLASS_W-1:0] cls;
    logic               take_item;
    logic               load_keep;
    logic               load_drop;
    logic               bump_loop;
    logic               clear_loop;
    logic               sweep_wb;
    logic               clearing;
    logic               show_result;
  } qfec_ctl_t;

endpackage

>>> hdl/qfec_ram.sv
// ---------------------------------------------------------------------------
// qfec_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module qfec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/qfec_ctrl.sv
// ---------------------------------------------------------------------------
// qfec_ctrl
// sequencer: clearing pass, label lookups, compare and relabel sweep
// ---------------------------------------------------------------------------
module qfec_ctrl
  import qfec_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int CW           = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            edge_valid,
  input  logic            result_ready,
  input  qfec_stat_t      stat,
  input  logic [CW-1:0]   n_eff,
  output qfec_ctl_t       ctl,
  output logic [CW-1:0]   cnt
);

  localparam logic [CW-1:0] CLEAR_LAST = CW'(MAX_VERTICES - 1);

  state_t             state, state_next;
  logic [CW-1:0]      cnt_next;
  logic               restart_flag;
  logic [CLASS_W-1:0] cls, cls_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CLEAR_LAST) begin
          state_next = restart_flag ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (edge_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.restart) begin
          state_next = ST_CLEAR;
        end else if (stat.invalid || stat.self_loop) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LOOK_LO;
        end
      end
      ST_LOOK_LO: state_next = ST_LOOK_HI;
      ST_LOOK_HI: state_next = ST_MATCH;
      ST_MATCH: begin
        state_next = stat.labels_equal ? ST_DONE : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (cnt == n_eff) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sweep and clear index
  always_comb begin
    cnt_next = cnt;
    case (state)
      ST_CHECK, ST_MATCH: cnt_next = '0;
      ST_CLEAR, ST_SWEEP: cnt_next = cnt + CW'(1);
      default:            cnt_next = cnt;
    endcase
  end

  // result class
  always_comb begin
    cls_next = cls;
    case (state)
      ST_CHECK: begin
        if (stat.restart) begin
          cls_next = CLS_RESTART;
        end else if (stat.invalid) begin
          cls_next = CLS_INVALID;
        end else begin
          cls_next = CLS_SELF_LOOP;
        end
      end
      ST_MATCH: cls_next = stat.labels_equal ? CLS_CYCLE : CLS_FOREST;
      default:  cls_next = cls;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cnt          <= '0;
      restart_flag <= 1'b0;
      cls          <= CLS_RESTART;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      cls   <= cls_next;
      if (state == ST_CHECK) begin
        restart_flag <= stat.restart;
      end
    end
  end

  // strobes
  always_comb begin
    ctl             = '0;
    ctl.state       = state;
    ctl.cls         = cls;
    ctl.take_item   = (state == ST_IDLE) && edge_valid;
    ctl.load_keep   = (state == ST_LOOK_HI);
    ctl.load_drop   = (state == ST_MATCH);
    ctl.bump_loop   = (state == ST_CHECK) && !stat.restart && !stat.invalid
                      && stat.self_loop;
    ctl.clear_loop  = (state == ST_CHECK) && stat.restart;
    ctl.sweep_wb    = (state == ST_SWEEP) && (cnt != '0);
    ctl.clearing    = (state == ST_CLEAR);
    ctl.show_result = (state == ST_DONE);
  end

endmodule

>>> hdl/quick_find_edge_classifier.sv
// steps: self loop and invalid requests go from the check to the result, a cycle edge
//   through both label lookups and the compare, a merging edge adds a relabel sweep of
//   n_eff labels, a restart a clearing pass; ready again once the result is taken
// throughput: one request at a time, set by the label ram sweep at one label per cycle
// reset: synchronous rst starts a clearing pass of MAX_VERTICES labels, edge_ready low
// reset: vertex_count returns to 256 and the self loop count to zero
// ---------------------------------------------------------------------------
// quick_find_edge_classifier
// quick find union over vertex labels, classifies each edge request
// ---------------------------------------------------------------------------
`include "quick_find_edge_classifier_defines.svh"

module quick_find_edge_classifier
  import qfec_pkg::*;
#(
  parameter int MAX_VERTICES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // edge requests
  input  logic                  edge_valid,
  output logic                  edge_ready,
  input  edge_req_t             edge_req,
  // results
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  localparam int AW     = $clog2(MAX_VERTICES);
  localparam int CLOG_N = $clog2(MAX_VERTICES + 1);
  localparam int CW     = ((CLOG_N > VCOUNT_W) ? CLOG_N : VCOUNT_W) + 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_VERTICES);

  logic [VCOUNT_W-1:0] vertex_count;
  logic [CW-1:0]       vc_ext, n_eff, hi_ext, cnt;
  logic                mode;
  logic [VERTEX_W-1:0] lo, hi, lo_in, hi_in;
  logic [AW+VERTEX_W-1:0] lo_addr_ext, hi_addr_ext;
  logic [AW-1:0]       keep, drop, cmp_ref, wb_addr;
  logic [AW-1:0]       ram_raddr, ram_waddr, ram_wdata, ram_rdata;
  logic                ram_we, labels_equal;
  logic [LOOP_W-1:0]   loop_count;
  qfec_stat_t          stat;
  qfec_ctl_t           ctl;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[VCOUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) begin
      prdata = {{(CFG_DATA_W-VCOUNT_W){1'b0}}, vertex_count};
    end
  end

  // effective vertex count, clamped to capacity
  assign vc_ext = {{(CW-VCOUNT_W){1'b0}}, vertex_count};
  assign n_eff  = (vc_ext > MAX_C) ? MAX_C : vc_ext;

  // request capture with ordered endpoints
  assign lo_in = (edge_req.vertex_a < edge_req.vertex_b) ? edge_req.vertex_a
                                                         : edge_req.vertex_b;
  assign hi_in = (edge_req.vertex_a < edge_req.vertex_b) ? edge_req.vertex_b
                                                         : edge_req.vertex_a;

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      mode <= edge_req.mode;
      lo   <= lo_in;
      hi   <= hi_in;
    end
  end

  assign hi_ext      = {{(CW-VERTEX_W){1'b0}}, hi};
  assign lo_addr_ext = {{AW{1'b0}}, lo};
  assign hi_addr_ext = {{AW{1'b0}}, hi};

  // shared label compare unit
  assign cmp_ref      = (ctl.state == ST_MATCH) ? keep : drop;
  assign labels_equal = (ram_rdata == cmp_ref);

  assign stat.restart      = mode;
  assign stat.invalid      = (hi_ext >= n_eff);
  assign stat.self_loop    = (lo == hi);
  assign stat.labels_equal = labels_equal;

  // label registers and write back address
  always_ff @(posedge clk) begin
    if (ctl.load_keep) begin
      keep <= ram_rdata;
    end
    if (ctl.load_drop) begin
      drop <= ram_rdata;
    end
    wb_addr <= cnt[AW-1:0];
  end

  // label ram ports
  always_comb begin
    case (ctl.state)
      ST_LOOK_LO: ram_raddr = lo_addr_ext[AW-1:0];
      ST_LOOK_HI: ram_raddr = hi_addr_ext[AW-1:0];
      ST_SWEEP:   ram_raddr = cnt[AW-1:0];
      default:    ram_raddr = '0;
    endcase
  end

  always_comb begin
    if (ctl.clearing) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = cnt[AW-1:0];
    end else begin
      ram_we    = ctl.sweep_wb && labels_equal;
      ram_waddr = wb_addr;
      ram_wdata = keep;
    end
  end

  qfec_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_VERTICES)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // saturating self loop count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_loop) begin
      loop_count <= '0;
    end else if (ctl.bump_loop && (loop_count != LOOP_MAX)) begin
      loop_count <= loop_count + LOOP_W'(1);
    end
  end

  qfec_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .CW           (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .edge_valid   (edge_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .n_eff        (n_eff),
    .ctl          (ctl),
    .cnt          (cnt)
  );

  // handshake and result
  assign edge_ready   = (ctl.state == ST_IDLE);
  assign result_valid = ctl.show_result;

  always_comb begin
    result.edge_class = ctl.cls;
    result.loop_total = loop_count;
    if (ctl.cls == CLS_RESTART) begin
      result.low_end  = '0;
      result.high_end = '0;
    end else begin
      result.low_end  = lo;
      result.high_end = hi;
    end
  end

  // checks
  `QFEC_ASSERT_SAME(a_one_request, edge_ready, !result_valid, "request taken while result pending")
  `QFEC_ASSERT_NEXT(a_loop_hold, ctl.state != ST_CHECK, $stable(loop_count), "loop count moved outside check")
  `QFEC_ASSERT_SAME(a_sweep_distinct, ctl.sweep_wb && ram_we, keep != drop, "relabel with equal labels")
  `QFEC_ASSERT_SAME(a_sweep_ordered, ctl.state == ST_SWEEP, lo < hi, "sweep on unordered endpoints")

endmodule
